FILE: rtl/core/frpt_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the frame-relative pose transform unit.
// Depends on nothing; every other file in rtl/core imports it.

package frpt_pkg;

  // Frame table geometry.
  localparam int MAX_FRAMES = 16;
  localparam int FRAME_W    = $clog2(MAX_FRAMES);
  localparam int COUNT_W    = FRAME_W + 1;
  localparam int REQ_W      = 8;
  localparam int CMP_W      = (COUNT_W > REQ_W) ? COUNT_W : REQ_W;
  localparam int FRAME_OUT_W = 4;

  // Angle quantization ahead of the sine evaluation.
  localparam int TRIG_TABLE_BITS = 12;
  localparam int TRIG_SHIFT      = 16 - TRIG_TABLE_BITS;

  // Polynomial sine constants, Q14 domain.
  localparam logic [15:0] QUARTER_TURN = 16'd16384;
  localparam logic [15:0] SIN_C1       = 16'd2320;
  localparam logic [15:0] SIN_C2       = 16'd21024;
  localparam logic [15:0] SIN_C3       = 16'd51472;
  localparam logic [15:0] SIN_MAX      = 16'd32767;

  // One frame origin as held in the table.
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [15:0] angle;
  } origin_t;

endpackage

FILE: rtl/core/frame_relative_pose_transform_unit.sv
`timescale 1ns / 1ps
// Top level of the frame-relative pose transform: frame table control,
// rotation datapath and result registers. Depends on frpt_pkg,
// frpt_origin_mem and frpt_trig.
//
//   Channel   Ports                                    Handshake
//   --------  ---------------------------------------  ------------------------
//   item in   pose_x/y/angle, switches, frame_request  start_i high, busy_o low
//   result    rel_x/y/angle, frame_used, current, full  valid_o for one cycle
//
// The next item is taken in the cycle that shows the result. An item passes
// through the registered table read, the four-step sine polynomial and the two
// rounds of the two rotation multipliers. Reset clears the frame count to one and
// the current frame to zero; table entry 0 reads as the world origin without a
// clearing pass. The result cannot be held off, so the output side never stalls;
// busy_o holds off new items while one is in flight.

module frame_relative_pose_transform_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic signed [31:0]                   pose_x_i,
  input  logic signed [31:0]                   pose_y_i,
  input  logic signed [15:0]                   pose_angle_i,
  input  logic                                 front_switch_i,
  input  logic                                 side_switch_i,
  input  logic [frpt_pkg::REQ_W-1:0]           frame_request_i,
  output logic                                 valid_o,
  output logic signed [31:0]                   rel_x_o,
  output logic signed [31:0]                   rel_y_o,
  output logic signed [15:0]                   rel_angle_o,
  output logic [frpt_pkg::FRAME_OUT_W-1:0]     frame_used_o,
  output logic [frpt_pkg::FRAME_OUT_W-1:0]     current_frame_out_o,
  output logic                                 table_full_o
);
  import frpt_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_ORIG = 3'd2;
  localparam logic [2:0] S_TRIG = 3'd3;
  localparam logic [2:0] S_ROT2 = 3'd4;
  localparam logic [2:0] S_ROT3 = 3'd5;

  logic [2:0]         state_q, state_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [FRAME_W-1:0] cur_q, cur_d;
  logic [FRAME_W-1:0] fr_q, fr_d;
  logic               full_q;
  logic               valid_q;

  logic               accept;
  logic               both_sw;
  logic               has_room;
  logic               append;

  logic signed [31:0] px_q, py_q;
  logic [15:0]        pa_q;
  logic signed [32:0] dx_q, dy_q;
  logic [15:0]        rel_ang_q;
  logic signed [31:0] rel_x_q, rel_y_q;
  logic signed [48:0] pa_prod_q, pb_prod_q;
  logic signed [48:0] pa_prod, pb_prod;
  logic signed [32:0] mul_a_op, mul_b_op;
  logic signed [49:0] sum_x, sum_y;

  origin_t            wr_origin;
  origin_t            rd_origin;
  origin_t            origin;
  logic [15:0]        trig_ang;
  logic               trig_start;
  logic               trig_done;
  logic signed [15:0] sin_v, cos_v;

  // Round half up by 2^15, then clamp to the signed 32-bit range.
  function automatic logic [31:0] rnd_sat(input logic signed [49:0] v);
    logic signed [49:0] t;
    logic [34:0]        q;
    t = v + 50'sd16384;
    q = 35'(t >>> 15);
    if (q[34:31] == 4'b0000 || q[34:31] == 4'b1111) begin
      return q[31:0];
    end else if (q[34]) begin
      return 32'h8000_0000;
    end else begin
      return 32'h7FFF_FFFF;
    end
  endfunction

  // Frame table bookkeeping for an incoming item.
  assign busy_o   = (state_q != S_IDLE);
  assign accept   = start_i && !busy_o;
  assign both_sw  = front_switch_i && side_switch_i;
  assign has_room = (count_q < COUNT_W'(MAX_FRAMES));
  assign append   = both_sw && has_room;

  always_comb begin
    count_d = append ? count_q + COUNT_W'(1) : count_q;
    cur_d   = append ? count_q[FRAME_W-1:0] : cur_q;
    fr_d    = (CMP_W'(frame_request_i) < CMP_W'(count_d)) ? FRAME_W'(frame_request_i)
                                                            : cur_d;
  end

  assign wr_origin.x     = pose_x_i;
  assign wr_origin.y     = pose_y_i;
  assign wr_origin.angle = pose_angle_i;

  frpt_origin_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (accept && append),
    .waddr_i (count_q[FRAME_W-1:0]),
    .wdata_i (wr_origin),
    .re_i    (state_q == S_READ),
    .raddr_i (fr_q),
    .rdata_o (rd_origin)
  );

  // Frame 0 is the world origin and is never written.
  assign origin     = (fr_q == '0) ? '0 : rd_origin;
  assign trig_ang   = (origin.angle >> TRIG_SHIFT) << TRIG_SHIFT;
  assign trig_start = (state_q == S_ORIG);

  frpt_trig u_trig (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (trig_start),
    .angle_i (trig_ang),
    .done_o  (trig_done),
    .sin_o   (sin_v),
    .cos_o   (cos_v)
  );

  // Two rotation multipliers, swapped operands on the second round.
  assign mul_a_op = (state_q == S_ROT2) ? dy_q : dx_q;
  assign mul_b_op = (state_q == S_ROT2) ? dx_q : dy_q;
  assign pa_prod  = mul_a_op * cos_v;
  assign pb_prod  = mul_b_op * sin_v;
  assign sum_x    = {pa_prod_q[48], pa_prod_q} + {pb_prod_q[48], pb_prod_q};
  assign sum_y    = {pa_prod_q[48], pa_prod_q} - {pb_prod_q[48], pb_prod_q};

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (accept) state_d = S_READ;
      S_READ: state_d = S_ORIG;
      S_ORIG: state_d = S_TRIG;
      S_TRIG: if (trig_done) state_d = S_ROT2;
      S_ROT2: state_d = S_ROT3;
      S_ROT3: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= COUNT_W'(1);
      cur_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= (state_q == S_ROT3);
      if (accept) begin
        count_q <= count_d;
        cur_q   <= cur_d;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q   <= pose_x_i;
      py_q   <= pose_y_i;
      pa_q   <= pose_angle_i;
      fr_q   <= fr_d;
      full_q <= both_sw && !has_room;
    end
    if (state_q == S_ORIG) begin
      dx_q      <= {px_q[31], px_q} - {origin.x[31], origin.x};
      dy_q      <= {py_q[31], py_q} - {origin.y[31], origin.y};
      rel_ang_q <= pa_q - origin.angle;
    end
    if ((state_q == S_TRIG && trig_done) || state_q == S_ROT2) begin
      pa_prod_q <= pa_prod;
      pb_prod_q <= pb_prod;
    end
    if (state_q == S_ROT2) begin
      rel_x_q <= rnd_sat(sum_x);
    end
    if (state_q == S_ROT3) begin
      rel_y_q <= rnd_sat(sum_y);
    end
  end

  assign valid_o             = valid_q;
  assign rel_x_o             = rel_x_q;
  assign rel_y_o             = rel_y_q;
  assign rel_angle_o         = rel_ang_q;
  assign frame_used_o        = FRAME_OUT_W'(fr_q);
  assign current_frame_out_o = FRAME_OUT_W'(cur_q);
  assign table_full_o        = full_q;

endmodule

FILE: rtl/core/frpt_origin_mem.sv
`timescale 1ns / 1ps
// Frame origin table: one write port, one read port with registered data.
// Depends on frpt_pkg for the origin record and table size.

module frpt_origin_mem (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [frpt_pkg::FRAME_W-1:0]   waddr_i,
  input  frpt_pkg::origin_t              wdata_i,
  input  logic                           re_i,
  input  logic [frpt_pkg::FRAME_W-1:0]   raddr_i,
  output frpt_pkg::origin_t              rdata_o
);
  import frpt_pkg::*;

  origin_t mem [MAX_FRAMES];
  origin_t rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port with registered data.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/frpt_trig.sv
`timescale 1ns / 1ps
// Sine and cosine of a binary angle in Q1.15, two lanes in parallel.
// Each lane runs the polynomial over four multiply steps. Depends on frpt_pkg.

module frpt_trig (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [15:0]        angle_i,
  output logic               done_o,
  output logic signed [15:0] sin_o,
  output logic signed [15:0] cos_o
);
  import frpt_pkg::*;

  logic [15:0] lane_ang [2];
  logic [14:0] fold_z   [2];
  logic [15:0] op_a     [2];
  logic [15:0] op_b     [2];
  logic [31:0] prod     [2];
  logic [15:0] mag      [2];
  logic signed [15:0] res [2];

  logic [14:0] z_q   [2];
  logic        neg_q [2];
  logic [15:0] z2_q  [2];
  logic [15:0] acc_q [2];
  logic [1:0]  ph_q;
  logic        run_q;
  logic        done_q;

  // Lane 0 evaluates sine, lane 1 evaluates sine a quarter turn later.
  assign lane_ang[0] = angle_i;
  assign lane_ang[1] = angle_i + QUARTER_TURN;

  // Fold into the first quadrant and pick multiplier operands per step.
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      fold_z[l] = lane_ang[l][14] ? 15'(15'd16384 - {1'b0, lane_ang[l][13:0]})
                                  : {1'b0, lane_ang[l][13:0]};
      case (ph_q)
        2'd0: begin
          op_a[l] = {1'b0, z_q[l]};
          op_b[l] = {1'b0, z_q[l]};
        end
        2'd1: begin
          op_a[l] = SIN_C1;
          op_b[l] = acc_q[l];
        end
        2'd2: begin
          op_a[l] = SIN_C2 - acc_q[l];
          op_b[l] = z2_q[l];
        end
        2'd3: begin
          op_a[l] = {1'b0, z_q[l]};
          op_b[l] = SIN_C3 - acc_q[l];
        end
        default: begin
          op_a[l] = {1'b0, z_q[l]};
          op_b[l] = {1'b0, z_q[l]};
        end
      endcase
      prod[l] = op_a[l] * op_b[l];
      mag[l]  = (acc_q[l] > SIN_MAX) ? SIN_MAX : acc_q[l];
      res[l]  = neg_q[l] ? -$signed(mag[l]) : $signed(mag[l]);
    end
  end

  // Step sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= 2'd0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= run_q && (ph_q == 2'd3);
      if (start_i) begin
        ph_q  <= 2'd0;
        run_q <= 1'b1;
      end else if (run_q) begin
        ph_q <= ph_q + 2'd1;
        if (ph_q == 2'd3) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  // Lane datapath: load the folded angle, then keep each scaled product.
  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 2; l++) begin
      if (start_i) begin
        z_q[l]   <= fold_z[l];
        neg_q[l] <= lane_ang[l][15];
      end else if (run_q) begin
        acc_q[l] <= prod[l][29:14];
        if (ph_q == 2'd0) begin
          z2_q[l] <= prod[l][29:14];
        end
      end
    end
  end

  assign done_o = done_q;
  assign sin_o  = res[0];
  assign cos_o  = res[1];

endmodule
